@@ hw/rtl/spi_pkg.sv @@
// package for the segment / plane intersection core
// holds fixed-point constants, config register indexes and stage types; no dependencies
package spi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int TOL_W     = 31;
  // shifted product width: 64-bit product >> FRAC_BITS
  localparam int PW        = 2 * DW - FRAC_BITS;
  // dot product sum width (three terms)
  localparam int SW        = PW + 2;
  // den / num width
  localparam int DNW       = SW + 1;
  // quotient width, holds 0 .. 2^FRAC_BITS
  localparam int QW        = FRAC_BITS + 1;
  // divider steps per pipeline stage
  localparam int DIV_STEP  = 4;
  localparam int DIV_STG   = (FRAC_BITS + DIV_STEP - 1) / DIV_STEP;

  typedef enum logic [2:0] {
    REG_NORMAL_X   = 3'd0,
    REG_NORMAL_Y   = 3'd1,
    REG_NORMAL_Z   = 3'd2,
    REG_PLANE_OFS  = 3'd3,
    REG_ZERO_TOL   = 3'd4
  } cfg_idx_t;

  typedef logic signed [DW-1:0] coord_t;

  // one divider stage: remainder, partial quotient, divisor, flags, start point and deltas
  typedef struct packed {
    logic            vld;
    logic            hit;
    logic            one;
    logic [DNW-1:0]  rem;
    logic [DNW-1:0]  aden;
    logic [QW-1:0]   q;
    coord_t          sx, sy, sz;
    logic signed [DW:0] dx, dy, dz;
  } div_stage_t;

endpackage

@@ hw/rtl/segment_plane_intersect_core.sv @@
// segment / plane intersection core, Q16.16 fixed point
// pipeline: stages 1 to 4, the divider stages, then lerp stages a and b, all registered
// throughput: one segment per cycle; start may be high every cycle, busy stays low
// each stage is a registered multiply, add, compare or 4 divider steps
// reset (rst_n low, synchronous) clears valid bits and loads normal x=1.0 (plane x=0), tolerance 1
// the receiver cannot stall: each result shows for one cycle with out_valid
module segment_plane_intersect_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_start_x,
  input  logic signed [31:0]   in_start_y,
  input  logic signed [31:0]   in_start_z,
  input  logic signed [31:0]   in_end_x,
  input  logic signed [31:0]   in_end_y,
  input  logic signed [31:0]   in_end_z,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic signed [31:0]   out_point_x,
  output logic signed [31:0]   out_point_y,
  output logic signed [31:0]   out_point_z
);

  localparam int DW  = spi_pkg::DW;
  localparam int PW  = spi_pkg::PW;
  localparam int SW  = spi_pkg::SW;
  localparam int DNW = spi_pkg::DNW;
  localparam int QW  = spi_pkg::QW;
  localparam int FB  = spi_pkg::FRAC_BITS;
  localparam int NST = spi_pkg::DIV_STG;
  localparam int STP = spi_pkg::DIV_STEP;

  assign busy = 1'b0;

  // configuration registers
  logic signed [DW-1:0] nx_r, ny_r, nz_r, ofs_r;
  logic [spi_pkg::TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= DW'(64'sd1 <<< FB);
      ny_r  <= '0;
      nz_r  <= '0;
      ofs_r <= '0;
      tol_r <= spi_pkg::TOL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        spi_pkg::REG_NORMAL_X:  nx_r  <= cfg_data;
        spi_pkg::REG_NORMAL_Y:  ny_r  <= cfg_data;
        spi_pkg::REG_NORMAL_Z:  nz_r  <= cfg_data;
        spi_pkg::REG_PLANE_OFS: ofs_r <= cfg_data;
        spi_pkg::REG_ZERO_TOL:  tol_r <= cfg_data[spi_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: six products, shifted (arithmetic shift is floor)
  logic                 v1_r;
  logic signed [PW-1:0] p1_r [6];
  spi_pkg::coord_t      sx1_r, sy1_r, sz1_r, ex1_r, ey1_r, ez1_r;
  logic signed [2*DW-1:0] prod [6];

  always_comb begin
    prod[0] = nx_r * in_start_x;
    prod[1] = ny_r * in_start_y;
    prod[2] = nz_r * in_start_z;
    prod[3] = nx_r * in_end_x;
    prod[4] = ny_r * in_end_y;
    prod[5] = nz_r * in_end_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) p1_r[i] <= PW'(prod[i] >>> FB);
    sx1_r <= in_start_x; sy1_r <= in_start_y; sz1_r <= in_start_z;
    ex1_r <= in_end_x;   ey1_r <= in_end_y;   ez1_r <= in_end_z;
  end

  // stage 2: dot product sums
  logic                 v2_r;
  logic signed [SW-1:0] sd2_r, ed2_r;
  spi_pkg::coord_t      sx2_r, sy2_r, sz2_r, ex2_r, ey2_r, ez2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    sd2_r <= SW'(p1_r[0]) + SW'(p1_r[1]) + SW'(p1_r[2]);
    ed2_r <= SW'(p1_r[3]) + SW'(p1_r[4]) + SW'(p1_r[5]);
    sx2_r <= sx1_r; sy2_r <= sy1_r; sz2_r <= sz1_r;
    ex2_r <= ex1_r; ey2_r <= ey1_r; ez2_r <= ez1_r;
  end

  // stage 3: denominator, numerator, and coordinate deltas
  logic                  v3_r;
  logic signed [DNW-1:0] den3_r, num3_r;
  spi_pkg::coord_t       sx3_r, sy3_r, sz3_r;
  logic signed [DW:0]    dx3_r, dy3_r, dz3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    den3_r <= DNW'(ed2_r) - DNW'(sd2_r);
    num3_r <= DNW'(ofs_r) - DNW'(sd2_r);
    sx3_r  <= sx2_r; sy3_r <= sy2_r; sz3_r <= sz2_r;
    dx3_r  <= (DW+1)'(ex2_r) - (DW+1)'(sx2_r);
    dy3_r  <= (DW+1)'(ey2_r) - (DW+1)'(sy2_r);
    dz3_r  <= (DW+1)'(ez2_r) - (DW+1)'(sz2_r);
  end

  // stage 4: magnitudes, parallel and range test, divider setup
  spi_pkg::div_stage_t d_r [NST+1];
  logic [DNW-1:0] aden4, anum4;
  logic           hit4;

  always_comb begin
    aden4 = den3_r[DNW-1] ? DNW'(-den3_r) : DNW'(den3_r);
    anum4 = num3_r[DNW-1] ? DNW'(-num3_r) : DNW'(num3_r);
    hit4  = (den3_r != '0) && (aden4 >= DNW'(tol_r)) &&
            (num3_r == '0 || (num3_r[DNW-1] == den3_r[DNW-1])) &&
            (anum4 <= aden4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r[0] <= '0;
    end else begin
      d_r[0].vld  <= v3_r;
      d_r[0].hit  <= hit4;
      d_r[0].one  <= (anum4 == aden4);
      d_r[0].rem  <= anum4;
      d_r[0].aden <= aden4;
      d_r[0].q    <= '0;
      d_r[0].sx   <= sx3_r; d_r[0].sy <= sy3_r; d_r[0].sz <= sz3_r;
      d_r[0].dx   <= dx3_r; d_r[0].dy <= dy3_r; d_r[0].dz <= dz3_r;
    end
  end

  // divider stages: restoring division, STP quotient bits per stage
  for (genvar g = 0; g < NST; g++) begin : g_div
    localparam int NB = ((g + 1) * STP > FB) ? (FB - g * STP) : STP;
    spi_pkg::div_stage_t nxt;
    logic [DNW:0] r;

    always_comb begin
      nxt = d_r[g];
      for (int k = 0; k < NB; k++) begin
        r = {nxt.rem, 1'b0};
        nxt.q = {nxt.q[QW-2:0], 1'b0};
        if (r >= {1'b0, nxt.aden}) begin
          r = r - {1'b0, nxt.aden};
          nxt.q[0] = 1'b1;
        end
        nxt.rem = r[DNW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) d_r[g+1] <= '0;
      else        d_r[g+1] <= nxt;
    end
  end

  // lerp stage a: t * delta per axis
  localparam int MW = DW + 1 + QW + 1;
  spi_pkg::div_stage_t dl;
  logic signed [QW:0]   t_s;
  logic                 va_r, hita_r;
  logic signed [MW-1:0] mx_r, my_r, mz_r;
  spi_pkg::coord_t      sxa_r, sya_r, sza_r;

  assign dl  = d_r[NST];
  assign t_s = dl.one ? (QW+1)'(1 << FB) : {1'b0, dl.q};

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= dl.vld;
  end

  always_ff @(posedge clk) begin
    hita_r <= dl.hit;
    mx_r   <= MW'(t_s) * MW'(dl.dx);
    my_r   <= MW'(t_s) * MW'(dl.dy);
    mz_r   <= MW'(t_s) * MW'(dl.dz);
    sxa_r  <= dl.sx; sya_r <= dl.sy; sza_r <= dl.sz;
  end

  // lerp stage b: shift, add, clamp, zero on miss
  function automatic logic signed [DW-1:0] lerp_fin(input logic signed [DW-1:0] s,
                                                    input logic signed [MW-1:0] m);
    logic signed [MW-1:0] p;
    p = MW'(s) + (m >>> FB);
    if (p > MW'(64'sh7FFF_FFFF))       lerp_fin = {1'b0, {(DW-1){1'b1}}};
    else if (p < -MW'(64'sh8000_0000)) lerp_fin = {1'b1, {(DW-1){1'b0}}};
    else                               lerp_fin = p[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= va_r;
  end

  always_ff @(posedge clk) begin
    out_hit     <= hita_r;
    out_point_x <= hita_r ? lerp_fin(sxa_r, mx_r) : '0;
    out_point_y <= hita_r ? lerp_fin(sya_r, my_r) : '0;
    out_point_z <= hita_r ? lerp_fin(sza_r, mz_r) : '0;
  end

endmodule

@@ dv/segment_plane_intersect_core_tb.sv @@
// testbench for segment_plane_intersect_core: directed and random segments against a local predictor
// depends on spi_pkg and the core rtl; a small scoreboard class holds expected result transactions
`timescale 1ns / 1ps

module segment_plane_intersect_core_tb;

  localparam int LATENCY  = 10;
  localparam int WD_LIMIT = 20000;

  typedef struct {
    logic        hit;
    logic [31:0] px, py, pz;
  } hit_rec_t;

  // expected result transactions (hit or miss) and mismatch bookkeeping
  class hit_scoreboard;
    hit_rec_t pending[$];
    int       errors;
    longint   nx, ny, nz, ofs;
    longint   tol;

    function new();
      errors = 0;
      nx = 65536; ny = 0; nz = 0; ofs = 0; tol = 1;
    endfunction

    function void set_reg(spi_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        spi_pkg::REG_NORMAL_X:  nx  = longint'($signed(v));
        spi_pkg::REG_NORMAL_Y:  ny  = longint'($signed(v));
        spi_pkg::REG_NORMAL_Z:  nz  = longint'($signed(v));
        spi_pkg::REG_PLANE_OFS: ofs = longint'($signed(v));
        spi_pkg::REG_ZERO_TOL:  tol = longint'({1'b0, v[30:0]});
        default: ;
      endcase
    endfunction

    // arithmetic shift of a signed value is floor division
    function longint fshr(longint v);
      return v >>> spi_pkg::FRAC_BITS;
    endfunction

    function logic [31:0] lerp(longint s, longint e, longint t);
      longint p;
      p = s + fshr(t * (e - s));
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
    endfunction

    // note an accepted segment and predict its transaction
    function void add_segment(logic [31:0] c[6]);
      longint   sx, sy, sz, ex, ey, ez, sd, ed, den, num, aden, anum, q, r;
      hit_rec_t h;
      bit       ok;
      sx = longint'($signed(c[0])); sy = longint'($signed(c[1]));
      sz = longint'($signed(c[2])); ex = longint'($signed(c[3]));
      ey = longint'($signed(c[4])); ez = longint'($signed(c[5]));
      sd = fshr(nx * sx) + fshr(ny * sy) + fshr(nz * sz);
      ed = fshr(nx * ex) + fshr(ny * ey) + fshr(nz * ez);
      den = ed - sd;
      num = ofs - sd;
      aden = den < 0 ? -den : den;
      anum = num < 0 ? -num : num;
      h = '{1'b0, 32'd0, 32'd0, 32'd0};
      if (den != 0 && aden >= tol) begin
        if (den > 0) ok = (num >= 0) && (num <= den);
        else ok = (num <= 0) && (num >= den);
        if (ok) begin
          if (anum == aden) q = 1 << spi_pkg::FRAC_BITS;
          else begin
            r = anum; q = 0;
            for (int i = 0; i < spi_pkg::FRAC_BITS; i++) begin
              r = r << 1; q = q << 1;
              if (r >= aden) begin
                r = r - aden; q = q | 1;
              end
            end
          end
          h.hit = 1'b1;
          h.px = lerp(sx, ex, q);
          h.py = lerp(sy, ey, q);
          h.pz = lerp(sz, ez, q);
        end
      end
      pending.push_back(h);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic hit, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      hit_rec_t h;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0b", hit);
        return;
      end
      h = pending.pop_front();
      if (h.hit !== hit || h.px !== px || h.py !== py || h.pz !== pz) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %0b %h %h %h got %0b %h %h %h",
                   h.hit, h.px, h.py, h.pz, hit, px, py, pz);
      end
    endfunction
  endclass

  logic        clk, rst_n, start, busy, cfg_we;
  logic [31:0] in_sx, in_sy, in_sz, in_ex, in_ey, in_ez, cfg_data;
  logic [2:0]  cfg_index;
  logic        out_valid, out_hit;
  logic [31:0] out_px, out_py, out_pz;
  hit_scoreboard sb;
  int          idle_cycles;

  segment_plane_intersect_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_sx), .in_start_y(in_sy), .in_start_z(in_sz),
    .in_end_x(in_ex), .in_end_y(in_ey), .in_end_z(in_ez),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_point_x(out_px), .out_point_y(out_py), .out_point_z(out_pz)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_hit, out_px, out_py, out_pz);
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      2: return 32'($signed($urandom_range(0, 40)) - 20) << 16;
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
    endcase
  endfunction

  task automatic wait_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_segment(logic [31:0] c[6]);
    in_sx = c[0]; in_sy = c[1]; in_sz = c[2];
    in_ex = c[3]; in_ey = c[4]; in_ez = c[5];
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.add_segment(c);
    @(negedge clk);
    start = 1'b0;
  endtask

  // drain all expected transactions, then let the pipe empty
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(spi_pkg::cfg_idx_t idx, logic [31:0] v);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    sb.set_reg(idx, v);
    cfg_we = 1'b0;
  endtask

  task automatic random_segment(bit streaming);
    logic [31:0] c[6];
    foreach (c[i]) c[i] = rnd_coord();
    // most segments straddle x = plane so hits are frequent
    if ($urandom_range(0, 3) != 0) begin
      c[0] = 32'($signed($urandom_range(0, 200)) - 100) << 14;
      c[3] = ~c[0] + 32'($urandom_range(0, 70000));
    end
    send_segment(c);
    if (!streaming) wait_gap();
  endtask

  initial begin
    logic [31:0] c[6];
    sb = new();
    idle_cycles = 0;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = spi_pkg::REG_NORMAL_X;
    cfg_data = '0;
    in_sx = '0; in_sy = '0; in_sz = '0; in_ex = '0; in_ey = '0; in_ez = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset plane x = 0
    c = '{32'hffff0000, 0, 0, 32'h00010000, 0, 0}; send_segment(c);
    c = '{0, 5, 6, 32'h00020000, 7, 8}; send_segment(c);
    c = '{32'h00020000, 1, 1, 32'h00020000, 2, 2}; send_segment(c);
    c = '{32'h00010000, 0, 0, 32'h00030000, 0, 0}; send_segment(c);
    c = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h7fffffff}; send_segment(c);
    c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff}; send_segment(c);
    c = '{5, 0, 0, 5, 1, 1}; send_segment(c);
    c = '{32'h00010000, 3, 3, 32'hffff0000, 9, 9}; send_segment(c);
    drain();
    // zero tolerance: a zero denominator still counts as parallel
    write_reg(spi_pkg::REG_ZERO_TOL, 32'h0);
    c = '{1, 2, 3, 1, 4, 5}; send_segment(c);
    c = '{32'hffffffff, 0, 0, 1, 0, 0}; send_segment(c);
    drain();
    // extreme normal and offset, huge tolerance, stray index
    write_reg(spi_pkg::REG_NORMAL_X, 32'h80000000);
    write_reg(spi_pkg::REG_NORMAL_Y, 32'h7fffffff);
    write_reg(spi_pkg::REG_NORMAL_Z, 32'hffffffff);
    write_reg(spi_pkg::REG_PLANE_OFS, 32'h7fffffff);
    write_reg(spi_pkg::REG_ZERO_TOL, 32'hffffffff);
    write_reg(spi_pkg::cfg_idx_t'(3'd6), 32'h12345678);
    c = '{32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_segment(c);
    drain();
    write_reg(spi_pkg::REG_ZERO_TOL, 32'h1);
    send_segment(c);
    c = '{0, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff}; send_segment(c);
    drain();

    // random phases under differing plane settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(spi_pkg::REG_NORMAL_X, 32'h00010000); write_reg(spi_pkg::REG_NORMAL_Y, 0);
          write_reg(spi_pkg::REG_NORMAL_Z, 0); write_reg(spi_pkg::REG_PLANE_OFS, 0);
          write_reg(spi_pkg::REG_ZERO_TOL, 1);
        end
        1: write_reg(spi_pkg::REG_PLANE_OFS, 32'h00008000);
        2: write_reg(spi_pkg::REG_ZERO_TOL, 32'h7fffffff);
        3: write_reg(spi_pkg::REG_ZERO_TOL, 0);
        default: begin
          write_reg(spi_pkg::REG_NORMAL_X, $urandom());
          write_reg(spi_pkg::REG_NORMAL_Y, $urandom_range(0, 1) ? $urandom() : 32'h0);
          write_reg(spi_pkg::REG_NORMAL_Z, $urandom_range(0, 1) ? $urandom() : 32'h0);
          write_reg(spi_pkg::REG_PLANE_OFS, $urandom());
          write_reg(spi_pkg::REG_ZERO_TOL,
                    $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 9)));
        end
      endcase
      for (int k = 0; k < 80; k++) random_segment(ph == 1 || (k > 30 && k < 50));
      drain();
    end

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
